FILE: hdl/rhg_pkg.sv
package rhg_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SATURATION   = 2'd0,
    CFG_LIGHTNESS    = 2'd1,
    CFG_HUE_STEP     = 2'd2,
    CFG_UPDATE_DELAY = 2'd3
  } cfg_idx_e;

  // Fixed field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 16;

  // Colour channel being worked on
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } ch_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;       // request accepted: decide update, advance hue and schedule
    logic load_grey;   // zero saturation: all channels take lightness
    logic mul_q;       // multiply for the high-side value
    logic fin_q;       // finish and saturate the high-side value
    logic calc_p;      // low-side value
    logic ramp_setup;  // hue offset, segment and ramp factor for one channel
    logic ramp_mul;    // span times ramp factor
    logic ramp_fin;    // add, limit and store one channel
    logic load_out;    // copy the colour into the output register
    ch_e  ch;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic upd;
    logic sat_zero;
  } dp_status_t;

endpackage

FILE: hdl/rhg_if.sv
interface rhg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ticks;
  logic        restart;

  modport source (output valid, output now_ticks, output restart, input ready);
  modport sink (input valid, input now_ticks, input restart, output ready);
endinterface

interface rhg_out_if #(
  parameter int unsigned FracBits = 16
);
  logic                valid;
  logic                ready;
  logic [FracBits-1:0] red;
  logic [FracBits-1:0] green;
  logic [FracBits-1:0] blue;
  logic                updated;

  modport source (output valid, output red, output green, output blue, output updated,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input updated,
                output ready);
endinterface

FILE: hdl/rhg_ctrl.sv
module rhg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rhg_pkg::dp_status_t status_i,
  output rhg_pkg::dp_cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_GREY  = 4'd2;
  localparam logic [3:0] S_QMUL  = 4'd3;
  localparam logic [3:0] S_QFIN  = 4'd4;
  localparam logic [3:0] S_PCALC = 4'd5;
  localparam logic [3:0] S_RSET  = 4'd6;
  localparam logic [3:0] S_RMUL  = 4'd7;
  localparam logic [3:0] S_RFIN  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]  state_q, state_d;
  rhg_pkg::ch_e ch_q, ch_d;
  logic        out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence the conversion one step at a time
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cmd_o   = '0;
    cmd_o.ch = ch_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status_i.upd) begin
          state_d = S_OUT;
        end else if (status_i.sat_zero) begin
          state_d = S_GREY;
        end else begin
          state_d = S_QMUL;
        end
      end
      S_GREY: begin
        cmd_o.load_grey = 1'b1;
        state_d         = S_OUT;
      end
      S_QMUL: begin
        cmd_o.mul_q = 1'b1;
        state_d     = S_QFIN;
      end
      S_QFIN: begin
        cmd_o.fin_q = 1'b1;
        state_d     = S_PCALC;
      end
      S_PCALC: begin
        cmd_o.calc_p = 1'b1;
        ch_d         = rhg_pkg::CH_RED;
        state_d      = S_RSET;
      end
      S_RSET: begin
        cmd_o.ramp_setup = 1'b1;
        state_d          = S_RMUL;
      end
      S_RMUL: begin
        cmd_o.ramp_mul = 1'b1;
        state_d        = S_RFIN;
      end
      S_RFIN: begin
        cmd_o.ramp_fin = 1'b1;
        case (ch_q)
          rhg_pkg::CH_RED: begin
            ch_d    = rhg_pkg::CH_GREEN;
            state_d = S_RSET;
          end
          rhg_pkg::CH_GREEN: begin
            ch_d    = rhg_pkg::CH_BLUE;
            state_d = S_RSET;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= rhg_pkg::CH_RED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/rhg_datapath.sv
module rhg_datapath #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned CfgW     = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rhg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]              cfg_data_i,
  input  logic [rhg_pkg::TimeW-1:0]    now_ticks_i,
  input  logic                         restart_i,
  input  rhg_pkg::dp_cmd_t             cmd_i,
  output rhg_pkg::dp_status_t          status_o,
  output logic [FracBits-1:0]          red_o,
  output logic [FracBits-1:0]          green_o,
  output logic [FracBits-1:0]          blue_o,
  output logic                         updated_o
);

  localparam int unsigned F  = FracBits;
  localparam int unsigned FW = F + 3;       // ramp factor width
  localparam int unsigned PW = F + FW;      // product width

  localparam int unsigned OneI    = 1 << F;
  localparam int unsigned ThirdI  = (OneI + 1) / 3;
  localparam int unsigned SixthI  = (OneI + 3) / 6;
  localparam int unsigned TwoThI  = (2 * OneI + 1) / 3;

  localparam logic [F-1:0] FMASK      = F'(OneI - 1);
  localparam logic [F-1:0] FHALF      = F'(OneI >> 1);
  localparam logic [F-1:0] THIRD      = F'(ThirdI);
  localparam logic [F-1:0] SIXTH      = F'(SixthI);
  localparam logic [F-1:0] TWO_THIRDS = F'(TwoThI);
  localparam logic [F-1:0] STEP_RST   = F'(655 & (OneI - 1));

  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_e;

  // Configuration registers
  logic [F-1:0]                 sat_q, lit_q, step_q;
  logic [rhg_pkg::DelayW-1:0]   delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q   <= FMASK;
      lit_q   <= FHALF;
      step_q  <= STEP_RST;
      delay_q <= '0;
    end else if (cfg_we_i) begin
      case (rhg_pkg::cfg_idx_e'(cfg_idx_i))
        rhg_pkg::CFG_SATURATION:   sat_q   <= cfg_data_i[F-1:0];
        rhg_pkg::CFG_LIGHTNESS:    lit_q   <= cfg_data_i[F-1:0];
        rhg_pkg::CFG_HUE_STEP:     step_q  <= cfg_data_i[F-1:0];
        rhg_pkg::CFG_UPDATE_DELAY: delay_q <= cfg_data_i[rhg_pkg::DelayW-1:0];
        default: ;
      endcase
    end
  end

  // Update decision and schedule at request acceptance
  logic [rhg_pkg::TimeW:0]   sched_sum;
  logic [rhg_pkg::TimeW-1:0] sched_next;
  logic                      upd_now;

  assign sched_sum  = {1'b0, now_ticks_i} + {{(rhg_pkg::TimeW + 1 - rhg_pkg::DelayW){1'b0}}, delay_q};
  assign sched_next = sched_sum[rhg_pkg::TimeW] ? '1 : sched_sum[rhg_pkg::TimeW-1:0];

  logic [F-1:0]              hue_q, h_q;
  logic [rhg_pkg::TimeW-1:0] next_q;
  logic                      force_q, upd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q   <= '0;
      next_q  <= '0;
      force_q <= 1'b1;
      upd_q   <= 1'b0;
    end else if (cmd_i.start) begin
      upd_q <= upd_now;
      if (upd_now) begin
        hue_q   <= hue_q + step_q;
        next_q  <= sched_next;
        force_q <= 1'b0;
      end
    end
  end

  assign upd_now = restart_i || force_q || (now_ticks_i >= next_q);

  // Hue used by this conversion, taken before the advance
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      h_q <= hue_q;
    end
  end

  assign status_o.upd      = upd_q;
  assign status_o.sat_zero = (sat_q == '0);

  // Shared multiplier
  logic [F-1:0]  mul_a;
  logic [FW-1:0] mul_b;
  logic [PW-1:0] prod_q;
  logic [FW-1:0] prod_hi;
  logic          lt_half;

  logic [F-1:0]  span_q;
  logic [FW-1:0] fact_q;
  seg_e          seg_q;

  assign lt_half = (lit_q < FHALF);
  assign prod_hi = prod_q[PW-1:F];

  always_comb begin
    mul_a = span_q;
    mul_b = fact_q;
    if (cmd_i.mul_q) begin
      mul_a = lit_q;
      mul_b = lt_half ? FW'({1'b1, sat_q}) : FW'(sat_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_q || cmd_i.ramp_mul) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
    end
  end

  // High-side value, saturated to just below one
  logic [F+1:0] q_sum;
  logic [F-1:0] q_q, p_q;

  always_comb begin
    if (lt_half) begin
      q_sum = prod_hi[F+1:0];
    end else begin
      q_sum = {2'b00, lit_q} + {2'b00, sat_q} - prod_hi[F+1:0];
    end
  end

  // Low-side value, clamped to the range zero to q
  logic [F:0] two_l, p_diff;

  assign two_l  = {lit_q, 1'b0};
  assign p_diff = (two_l >= {1'b0, q_q}) ? (two_l - {1'b0, q_q}) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_q) begin
      q_q <= (q_sum > {2'b00, FMASK}) ? FMASK : q_sum[F-1:0];
    end
    if (cmd_i.calc_p) begin
      p_q <= (p_diff > {1'b0, q_q}) ? q_q : p_diff[F-1:0];
    end
  end

  // Ramp set-up: hue offset, segment and factor
  logic [F-1:0]  t_sel, base;
  logic [FW-1:0] fact_d;
  seg_e          seg_d;

  always_comb begin
    case (cmd_i.ch)
      rhg_pkg::CH_RED:   t_sel = h_q + THIRD;
      rhg_pkg::CH_GREEN: t_sel = h_q;
      default:           t_sel = h_q - THIRD;
    endcase
    if (t_sel < SIXTH) begin
      seg_d = SEG_RISE;
    end else if (t_sel < FHALF) begin
      seg_d = SEG_HIGH;
    end else if (t_sel < TWO_THIRDS) begin
      seg_d = SEG_FALL;
    end else begin
      seg_d = SEG_LOW;
    end
    base   = (seg_d == SEG_RISE) ? t_sel : (TWO_THIRDS - t_sel);
    fact_d = (FW'(base) << 2) + (FW'(base) << 1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ramp_setup) begin
      span_q <= q_q - p_q;
      fact_q <= fact_d;
      seg_q  <= seg_d;
    end
  end

  // Ramp finish: add to the low side and limit to q; flat segments take q or p
  logic [FW:0]   ramp_v;
  logic [F-1:0]  chan_d;

  assign ramp_v = {1'b0, FW'(p_q)} + {1'b0, prod_hi};

  always_comb begin
    case (seg_q)
      SEG_HIGH: chan_d = q_q;
      SEG_LOW:  chan_d = p_q;
      default:  chan_d = (ramp_v > {{(FW + 1 - F){1'b0}}, q_q}) ? q_q : ramp_v[F-1:0];
    endcase
  end

  // Colour state
  logic [F-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= FMASK;
      green_q <= '0;
      blue_q  <= '0;
    end else if (cmd_i.load_grey) begin
      red_q   <= lit_q;
      green_q <= lit_q;
      blue_q  <= lit_q;
    end else if (cmd_i.ramp_fin) begin
      case (cmd_i.ch)
        rhg_pkg::CH_RED:   red_q   <= chan_d;
        rhg_pkg::CH_GREEN: green_q <= chan_d;
        default:           blue_q  <= chan_d;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      red_o     <= red_q;
      green_o   <= green_q;
      blue_o    <= blue_q;
      updated_o <= upd_q;
    end
  end

endmodule

FILE: hdl/rainbow_hsl_to_rgb_generator_unit.sv
// Channel   Role     Payload
// in_if     sink     now_ticks (32), restart (1)
// out_if    source   red, green, blue (FracBits each), updated (1)
// cfg       write    cfg_we_i, cfg_idx_i (2), cfg_data_i (max of FracBits and 16)
//
// A recompute uses one shared multiplier, once for the high-side value and once
// per channel, three steps each. Zero saturation and an item without a
// recompute do not use the multiplier.
// Reset is asynchronous and active low; no clearing pass is needed.
// A new request is taken while a finished result waits; the next result then
// holds in the controller until the output register frees up.
module rainbow_hsl_to_rgb_generator_unit #(
  parameter int unsigned FracBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rhg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [((FracBits > 16) ? FracBits : 16)-1:0] cfg_data_i,
  rhg_in_if.sink                      in_if,
  rhg_out_if.source                   out_if
);

  localparam int unsigned CfgW = (FracBits > 16) ? FracBits : 16;

  rhg_pkg::dp_cmd_t    cmd;
  rhg_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  // Sequence the steps
  rhg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold state, configuration and arithmetic
  rhg_datapath #(
    .FracBits(FracBits),
    .CfgW    (CfgW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .now_ticks_i(in_if.now_ticks),
    .restart_i  (in_if.restart),
    .cmd_i      (cmd),
    .status_o   (status),
    .red_o      (out_if.red),
    .green_o    (out_if.green),
    .blue_o     (out_if.blue),
    .updated_o  (out_if.updated)
  );

endmodule

FILE: hdl/rhg_checker.sv
module rhg_checker #(
  parameter int unsigned FracBits = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [FracBits-1:0] red_i,
  input logic [FracBits-1:0] green_i,
  input logic [FracBits-1:0] blue_i,
  input logic                updated_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;
  logic       seen_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track requests taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seen_q <= 1'b0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        seen_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(red_i) && $stable(green_i)
      && $stable(blue_i) && $stable(updated_i)))
    else $error("result changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request taken while another is in work");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("result without a pending request");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 2'd2) |-> !in_ready_i)
    else $error("ready with both slots occupied");

  a_first_updates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !seen_q) |-> updated_i)
    else $error("first result after reset not recomputed");

endmodule

bind rainbow_hsl_to_rgb_generator_unit rhg_checker #(.FracBits(FracBits)) u_rhg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .red_i      (out_if.red),
  .green_i    (out_if.green),
  .blue_i     (out_if.blue),
  .updated_i  (out_if.updated)
);
